>>> sv/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 median filter
// Sizes, register codes, command codes and the item structs that travel
// between the front end, the column queue, the back end and the ports.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 2048;

  // column counter indexes the line buffers; row counter holds up to height-1
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CW1   = COL_W + 1;
  localparam int RW1   = ROW_W + 1;

  // register field widths
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;
  localparam int FLOOR_REG_W  = 8;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DARK_FLOOR   = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RESET = 12'd1024;
  localparam logic [FLOOR_REG_W-1:0]  DARK_FLOOR_RESET   = 8'd30;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // small queues between the parts
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic       command;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] median_value;
    logic       row_end;
    logic       frame_end;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  image_width;
    logic [HEIGHT_REG_W-1:0] image_height;
    logic [FLOOR_REG_W-1:0]  dark_floor;
  } cfg_t;

  // one 3-pixel window column with its position flags
  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
    logic       first_col;
    logic       last_col;
    logic       frame_row;
  } col_item_t;

endpackage

>>> sv/median_filter_3x3_floor_unit.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_floor_unit: streaming 3x3 median filter with dark floor
// Raster-order grey pixels in, edge-replicated 3x3 medians out, one row late.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   input    | push / full        | item: command, pixel
//   result   | empty / pop        | result: median_value, row_end,
//            |                    |         frame_end, last
//   config   | cfg_write          | cfg_index, cfg_data
//
// One item is accepted per cycle while full is low; a row's last column gives two
// result words, so the sustained result rate is set by the pop side.
// From accept to result shown an item passes line-buffer read, column queue,
// sort, window, median and result queue, and waits longer while queues hold words.
// Reset clears counters, queues and window; line buffers need no clearing.
// A stalled result side backs up through both queues to full.
// ----------------------------------------------------------------------------
module median_filter_3x3_floor_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  mf3_pkg::in_item_t                   item,
  output logic                                empty,
  input  logic                                pop,
  output mf3_pkg::out_item_t                  result,
  input  logic                                cfg_write,
  input  logic [mf3_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]      cfg_data
);

  mf3_pkg::cfg_t      cfg;
  logic               col_push, col_full, col_pop, col_empty;
  mf3_pkg::col_item_t col_in, col_out;
  logic               out_room, out_push0, out_push1;
  mf3_pkg::out_item_t out_data0, out_data1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= mf3_pkg::IMAGE_WIDTH_RESET;
      cfg.image_height <= mf3_pkg::IMAGE_HEIGHT_RESET;
      cfg.dark_floor   <= mf3_pkg::DARK_FLOOR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mf3_pkg::REG_IMAGE_WIDTH: begin
          cfg.image_width <= cfg_data[mf3_pkg::WIDTH_REG_W-1:0];
        end
        mf3_pkg::REG_IMAGE_HEIGHT: begin
          cfg.image_height <= cfg_data[mf3_pkg::HEIGHT_REG_W-1:0];
        end
        mf3_pkg::REG_DARK_FLOOR: begin
          cfg.dark_floor <= cfg_data[mf3_pkg::FLOOR_REG_W-1:0];
        end
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  mf3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cfg      (cfg),
    .col_push (col_push),
    .col_full (col_full),
    .col_data (col_in)
  );

  mf3_colq u_colq (
    .clk   (clk),
    .rst   (rst),
    .push  (col_push),
    .full  (col_full),
    .wdata (col_in),
    .pop   (col_pop),
    .empty (col_empty),
    .rdata (col_out)
  );

  mf3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .col_empty  (col_empty),
    .col_pop    (col_pop),
    .col_data   (col_out),
    .dark_floor (cfg.dark_floor),
    .out_room   (out_room),
    .out_push0  (out_push0),
    .out_push1  (out_push1),
    .out_data0  (out_data0),
    .out_data1  (out_data1)
  );

  mf3_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push0 (out_push0),
    .push1 (out_push1),
    .data0 (out_data0),
    .data1 (out_data1),
    .room  (out_room),
    .pop   (pop),
    .empty (empty),
    .head  (result)
  );

endmodule

>>> sv/mf3_front.sv
// ----------------------------------------------------------------------------
// mf3_front: input acceptance, raster counters and line buffers
// Drops misplaced items, reads both line buffers for the current column and
// hands a 3-pixel window column to the column queue.
// ----------------------------------------------------------------------------
module mf3_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mf3_pkg::in_item_t  item,
  input  mf3_pkg::cfg_t      cfg,
  output logic               col_push,
  input  logic               col_full,
  output mf3_pkg::col_item_t col_data
);

  logic [mf3_pkg::COL_W-1:0] column_count;
  logic [mf3_pkg::ROW_W-1:0] row_count;
  logic                      flushing;

  logic [mf3_pkg::CW1-1:0] eff_w;
  logic [mf3_pkg::RW1-1:0] eff_h;
  logic last_col, last_row, is_pix, live, take;

  logic [7:0] line_above     [mf3_pkg::MAX_WIDTH];
  logic [7:0] line_two_above [mf3_pkg::MAX_WIDTH];
  logic [7:0] rd_above, rd_two;

  logic                      s1_valid, s1_move;
  logic [mf3_pkg::COL_W-1:0] s1_addr;
  logic s1_wr, s1_emit, s1_top_two, s1_bot_px, s1_first, s1_last, s1_frame, s1_fwd;
  logic [7:0] s1_px, s1_fwd_data, two_val;

  always_comb begin
    if (cfg.image_width == '0) begin
      eff_w = mf3_pkg::CW1'(1);
    end else if (cfg.image_width > mf3_pkg::WIDTH_REG_W'(mf3_pkg::MAX_WIDTH)) begin
      eff_w = mf3_pkg::CW1'(mf3_pkg::MAX_WIDTH);
    end else begin
      eff_w = mf3_pkg::CW1'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      eff_h = mf3_pkg::RW1'(1);
    end else if (cfg.image_height > mf3_pkg::HEIGHT_REG_W'(mf3_pkg::MAX_HEIGHT)) begin
      eff_h = mf3_pkg::RW1'(mf3_pkg::MAX_HEIGHT);
    end else begin
      eff_h = mf3_pkg::RW1'(cfg.image_height);
    end
  end

  assign last_col = (mf3_pkg::CW1'(column_count) + mf3_pkg::CW1'(1)) >= eff_w;
  assign last_row = (mf3_pkg::RW1'(row_count) + mf3_pkg::RW1'(1)) >= eff_h;
  assign is_pix   = (item.command == mf3_pkg::CMD_PIXEL);
  assign live     = is_pix ? !flushing : flushing;

  // stage 1 leaves once its column is queued, or at once if it has none
  assign s1_move = s1_valid && (!s1_emit || !col_full);
  assign full    = s1_valid && !s1_move;
  assign take    = push && !full && live;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      flushing     <= 1'b0;
    end else if (take) begin
      if (!last_col) begin
        column_count <= column_count + mf3_pkg::COL_W'(1);
      end else if (is_pix) begin
        column_count <= '0;
        if (last_row) begin
          flushing <= 1'b1;
        end else begin
          row_count <= row_count + mf3_pkg::ROW_W'(1);
        end
      end else begin
        column_count <= '0;
        row_count    <= '0;
        flushing     <= 1'b0;
      end
    end
  end

  // line buffers: read-first, registered read
  always_ff @(posedge clk) begin
    if (take) begin
      rd_above <= line_above[column_count];
    end
    if (take && is_pix) begin
      line_above[column_count] <= item.pixel;
    end
  end

  // the row above moves down one line as stage 1 retires
  always_ff @(posedge clk) begin
    if (take) begin
      rd_two <= line_two_above[column_count];
    end
    if (s1_move && s1_wr) begin
      line_two_above[s1_addr] <= rd_above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr     <= column_count;
      s1_wr       <= is_pix;
      s1_emit     <= is_pix ? (row_count != '0) : 1'b1;
      s1_top_two  <= is_pix ? (row_count >= mf3_pkg::ROW_W'(2)) : (row_count != '0);
      s1_bot_px   <= is_pix;
      s1_px       <= item.pixel;
      s1_first    <= (column_count == '0);
      s1_last     <= last_col;
      s1_frame    <= !is_pix;
      // bypass the line-two write that lands at this same edge
      s1_fwd      <= s1_move && s1_wr && (s1_addr == column_count);
      s1_fwd_data <= rd_above;
    end
  end

  assign two_val = s1_fwd ? s1_fwd_data : rd_two;

  assign col_push           = s1_valid && s1_emit && !col_full;
  assign col_data.top       = s1_top_two ? two_val : rd_above;
  assign col_data.mid       = rd_above;
  assign col_data.bot       = s1_bot_px ? s1_px : rd_above;
  assign col_data.first_col = s1_first;
  assign col_data.last_col  = s1_last;
  assign col_data.frame_row = s1_frame;

endmodule

>>> sv/mf3_colq.sv
// ----------------------------------------------------------------------------
// mf3_colq: column queue between front end and back end
// Short first-in first-out store of window columns, one word in and one out.
// ----------------------------------------------------------------------------
module mf3_colq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mf3_pkg::col_item_t wdata,
  input  logic               pop,
  output logic               empty,
  output mf3_pkg::col_item_t rdata
);

  mf3_pkg::col_item_t       slots [mf3_pkg::Q_DEPTH];
  logic [mf3_pkg::Q_AW-1:0] wr_ptr, rd_ptr;
  logic [mf3_pkg::Q_AW:0]   count;
  logic                     do_push, do_pop;

  assign full    = (count == (mf3_pkg::Q_AW+1)'(mf3_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + mf3_pkg::Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + mf3_pkg::Q_AW'(1);
      end
      count <= count + (mf3_pkg::Q_AW+1)'(do_push) - (mf3_pkg::Q_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

>>> sv/mf3_outq.sv
// ----------------------------------------------------------------------------
// mf3_outq: result queue
// Takes up to two result words a cycle and shows the oldest on the output.
// ----------------------------------------------------------------------------
module mf3_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push0,
  input  logic               push1,
  input  mf3_pkg::out_item_t data0,
  input  mf3_pkg::out_item_t data1,
  output logic               room,
  input  logic               pop,
  output logic               empty,
  output mf3_pkg::out_item_t head
);

  mf3_pkg::out_item_t       slots [mf3_pkg::Q_DEPTH];
  logic [mf3_pkg::Q_AW-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [mf3_pkg::Q_AW:0]   count;
  logic                     do_pop;

  // room for two more words
  assign room    = (count <= (mf3_pkg::Q_AW+1)'(mf3_pkg::Q_DEPTH - 2));
  assign empty   = (count == '0);
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];
  assign wr_ptr1 = wr_ptr + mf3_pkg::Q_AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push0 && push1) begin
        wr_ptr <= wr_ptr + mf3_pkg::Q_AW'(2);
      end else if (push0) begin
        wr_ptr <= wr_ptr1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + mf3_pkg::Q_AW'(1);
      end
      count <= count + (mf3_pkg::Q_AW+1)'(push0) + (mf3_pkg::Q_AW+1)'(push1)
             - (mf3_pkg::Q_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      slots[wr_ptr] <= data0;
    end
    if (push1) begin
      slots[wr_ptr1] <= data1;
    end
  end

endmodule

>>> sv/mf3_back.sv
// ----------------------------------------------------------------------------
// mf3_back: window and median pipeline
// Sorts each incoming column, keeps the two previous sorted columns and
// forms up to two floored medians per column in three stages.
// ----------------------------------------------------------------------------
module mf3_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               col_empty,
  output logic               col_pop,
  input  mf3_pkg::col_item_t col_data,
  input  logic [7:0]         dark_floor,
  input  logic               out_room,
  output logic               out_push0,
  output logic               out_push1,
  output mf3_pkg::out_item_t out_data0,
  output mf3_pkg::out_item_t out_data1
);

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] md;
    logic [7:0] hi;
  } scol_t;

  typedef struct packed {
    logic [7:0] max_lo;
    logic [7:0] med_md;
    logic [7:0] min_hi;
  } stat_t;

  function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic scol_t sort3(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c);
    scol_t s;
    s.lo = min2(min2(a, b), c);
    s.md = med3(a, b, c);
    s.hi = max2(max2(a, b), c);
    return s;
  endfunction

  // median of nine = median of (max of lows, median of mids, min of highs)
  function automatic stat_t stats(input scol_t a, input scol_t b, input scol_t c);
    stat_t s;
    s.max_lo = max2(max2(a.lo, b.lo), c.lo);
    s.med_md = med3(a.md, b.md, c.md);
    s.min_hi = min2(min2(a.hi, b.hi), c.hi);
    return s;
  endfunction

  function automatic logic [7:0] floored(input stat_t s, input logic [7:0] fl);
    logic [7:0] m;
    m = med3(s.max_lo, s.med_md, s.min_hi);
    return (m < fl) ? 8'd0 : m;
  endfunction

  logic  en;
  logic  b0_valid, b0_first, b0_last, b0_frame;
  scol_t b0_col, win_p1, win_p2, p1, p2;
  stat_t stat_a, stat_b;

  logic  b1_v0, b1_v1, b1_re0, b1_fe0, b1_last0, b1_fe1;
  stat_t b1_stat0, b1_stat1;

  logic               b2_v0, b2_v1;
  mf3_pkg::out_item_t b2_res0, b2_res1;

  // the whole pipe advances together; stall while results cannot be queued
  assign en      = !(b2_v0 || b2_v1) || out_room;
  assign col_pop = en && !col_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid <= 1'b0;
      b1_v0    <= 1'b0;
      b1_v1    <= 1'b0;
      b2_v0    <= 1'b0;
      b2_v1    <= 1'b0;
    end else if (en) begin
      b0_valid <= !col_empty;
      b1_v0    <= b0_valid && (!b0_first || b0_last);
      b1_v1    <= b0_valid && !b0_first && b0_last;
      b2_v0    <= b1_v0;
      b2_v1    <= b1_v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_col   <= sort3(col_data.top, col_data.mid, col_data.bot);
      b0_first <= col_data.first_col;
      b0_last  <= col_data.last_col;
      b0_frame <= col_data.frame_row;
    end
  end

  // at the first column the window is the column itself
  assign p2     = b0_first ? b0_col : win_p2;
  assign p1     = b0_first ? b0_col : win_p1;
  assign stat_a = stats(p2, p1, b0_col);
  assign stat_b = stats(p1, b0_col, b0_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_p1 <= '0;
      win_p2 <= '0;
    end else if (en && b0_valid) begin
      win_p2 <= p1;
      win_p1 <= b0_col;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_stat0 <= stat_a;
      b1_stat1 <= stat_b;
      b1_re0   <= b0_first;
      b1_fe0   <= b0_first && b0_frame;
      b1_last0 <= b0_first || !b0_last;
      b1_fe1   <= b0_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_res0.median_value <= floored(b1_stat0, dark_floor);
      b2_res0.row_end      <= b1_re0;
      b2_res0.frame_end    <= b1_fe0;
      b2_res0.last         <= b1_last0;
      b2_res1.median_value <= floored(b1_stat1, dark_floor);
      b2_res1.row_end      <= 1'b1;
      b2_res1.frame_end    <= b1_fe1;
      b2_res1.last         <= 1'b1;
    end
  end

  assign out_push0 = en && b2_v0;
  assign out_push1 = en && b2_v1;
  assign out_data0 = b2_res0;
  assign out_data1 = b2_res1;

endmodule

>>> sv/mf3_checker.sv
// ----------------------------------------------------------------------------
// mf3_checker: port-level checks of the median filter
// Watches reset behavior, result flag consistency and result hold.
// ----------------------------------------------------------------------------
module mf3_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input mf3_pkg::out_item_t result
);

  // reset drains every queue and frees the input
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) $past(rst) |-> !full)
    else $error("input full after reset");

  // frame end only ever marks the last word of a row
  a_frame_on_row_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.frame_end) |-> result.row_end)
    else $error("frame_end without row_end");

  a_frame_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.frame_end) |-> result.last)
    else $error("frame_end on a word that is not last");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

endmodule

bind median_filter_3x3_floor_unit mf3_checker u_mf3_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
